>>> rtl/core/otslt_pkg.sv
// Shared types and constants for the offset to source line table.
package otslt_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam int OP_W     = 2;
    localparam int OFFSET_W = 32;
    localparam int LINE_W   = 24;
    localparam int COLUMN_W = 16;
    localparam int STATUS_W = 2;

    localparam int ITEM_BITS = OP_W + OFFSET_W + LINE_W + COLUMN_W;
    localparam int TDATA_W   = ((ITEM_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_FIND_LINE = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic read;
        logic check;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_search;
        logic search_done;
        logic match;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/otslt_datapath.sv
// Datapath: entry stores, search registers and output register.
module otslt_datapath
    import otslt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    input  ctl_cmd_t           cmd,
    output dp_status_t         stat
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [OFFSET_W-1:0] offset_mem [TABLE_ENTRIES];
    logic [LINE_W-1:0]   line_mem   [TABLE_ENTRIES];
    logic [COLUMN_W-1:0] column_mem [TABLE_ENTRIES];

    op_t                 in_op;
    logic [OFFSET_W-1:0] in_offset;
    logic [LINE_W-1:0]   in_line;
    logic [COLUMN_W-1:0] in_column;

    logic [CW-1:0]       count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    op_t                 op_reg, op_next;
    logic [OFFSET_W-1:0] key_off_reg, key_off_next;
    logic [LINE_W-1:0]   key_line_reg, key_line_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic                full_reg, full_next;
    logic                best_valid_reg, best_valid_next;
    logic                hit_reg, hit_next;
    logic [LINE_W-1:0]   best_line_reg, best_line_next;
    logic [COLUMN_W-1:0] best_col_reg, best_col_next;
    logic [OFFSET_W-1:0] found_off_reg, found_off_next;

    logic [OFFSET_W-1:0] rd_off_reg;
    logic [LINE_W-1:0]   rd_line_reg;
    logic [COLUMN_W-1:0] rd_col_reg;

    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid;
    logic [IW-1:0]       rd_addr;
    logic                table_full;
    logic                wr_en;
    logic                match;

    status_t             res_status;
    logic [OFFSET_W-1:0] res_off;
    logic [LINE_W-1:0]   res_line;
    logic [COLUMN_W-1:0] res_col;

    assign in_op     = op_t'(s_tdata[OP_W-1:0]);
    assign in_offset = s_tdata[OP_W +: OFFSET_W];
    assign in_line   = s_tdata[OP_W+OFFSET_W +: LINE_W];
    assign in_column = s_tdata[OP_W+OFFSET_W+LINE_W +: COLUMN_W];

    assign table_full = (count_reg == CW'(TABLE_ENTRIES));
    assign wr_en      = cmd.accept && (in_op == OP_APPEND) && !table_full;

    // floor((lo + hi - 1) / 2) with hi held as an exclusive bound
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);
    assign mid     = mid_sum[CW:1];
    assign rd_addr = (op_reg == OP_LOOKUP) ? mid[IW-1:0] : lo_reg[IW-1:0];
    assign match   = (op_reg == OP_FIND_LINE) && (rd_line_reg == key_line_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            offset_mem[count_reg[IW-1:0]] <= in_offset;
            line_mem[count_reg[IW-1:0]]   <= in_line;
            column_mem[count_reg[IW-1:0]] <= in_column;
        end
        if (cmd.read) begin
            rd_off_reg  <= offset_mem[rd_addr];
            rd_line_reg <= line_mem[rd_addr];
            rd_col_reg  <= column_mem[rd_addr];
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_off    = '0;
        res_line   = '0;
        res_col    = '0;
        case (op_reg)
            OP_APPEND: begin
                res_status = full_reg ? ST_FULL : ST_OK;
            end
            OP_LOOKUP: begin
                if (best_valid_reg) begin
                    res_line = best_line_reg;
                    res_col  = best_col_reg;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_FIND_LINE: begin
                if (hit_reg) begin
                    res_off = found_off_reg;
                end else begin
                    res_status = ST_NOT_FOUND;
                    res_off    = '1;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        op_next         = op_reg;
        key_off_next    = key_off_reg;
        key_line_next   = key_line_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        full_next       = full_reg;
        best_valid_next = best_valid_reg;
        hit_next        = hit_reg;
        best_line_next  = best_line_reg;
        best_col_next   = best_col_reg;
        found_off_next  = found_off_reg;

        if (cmd.accept) begin
            op_next         = in_op;
            key_off_next    = in_offset;
            key_line_next   = in_line;
            lo_next         = '0;
            hi_next         = count_reg;
            full_next       = table_full;
            best_valid_next = 1'b0;
            hit_next        = 1'b0;
            if (wr_en) begin
                count_next = count_reg + CW'(1);
            end
            if (in_op == OP_CLEAR) begin
                count_next = '0;
            end
        end

        if (cmd.check) begin
            if (op_reg == OP_LOOKUP) begin
                if (rd_off_reg <= key_off_reg) begin
                    best_valid_next = 1'b1;
                    best_line_next  = rd_line_reg;
                    best_col_next   = rd_col_reg;
                    lo_next         = mid + CW'(1);
                end else begin
                    hi_next = mid;
                end
            end else if (match) begin
                hit_next       = 1'b1;
                found_off_next = rd_off_reg;
            end else begin
                lo_next = lo_reg + CW'(1);
            end
        end

        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(TDATA_W - ITEM_BITS)'(0), res_col, res_line, res_off,
                             res_status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg    <= m_tdata_next;
        op_reg         <= op_next;
        key_off_reg    <= key_off_next;
        key_line_reg   <= key_line_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        full_reg       <= full_next;
        best_valid_reg <= best_valid_next;
        hit_reg        <= hit_next;
        best_line_reg  <= best_line_next;
        best_col_reg   <= best_col_next;
        found_off_reg  <= found_off_next;
    end

    assign stat.in_search   = (in_op == OP_LOOKUP) || (in_op == OP_FIND_LINE);
    assign stat.search_done = (op_reg == OP_LOOKUP) ? (lo_reg >= hi_reg)
                                                    : (lo_reg >= count_reg);
    assign stat.match       = match;
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/otslt_ctrl.sv
// Controller state machine: sequences accept, memory probes and result load.
module otslt_ctrl
    import otslt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = stat.in_search ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                if (stat.search_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.read   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.match ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/offset_to_source_line_table.sv
// Top level: offset to source line table with floor and reverse lookup.
// The next item is taken once the last result is loaded. Append and clear do no
// search; offset lookup runs p <= ceil(log2(count+1)) probes of one registered read
// plus one compare; line search probes up to count entries the same way, same port.
// A stalled output holds the controller in its result state and adds the stall.
// Reset clears the entry count, the output valid and the control state; stores are not cleared.
module offset_to_source_line_table
    import otslt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // operation, code_offset, source_line, source_column, zero pad
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status, found_offset, found_line, found_column, zero pad
    output logic [TDATA_W-1:0] m_tdata
);

    ctl_cmd_t   cmd;
    dp_status_t stat;

    otslt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    otslt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> rtl/core/otslt_checker.sv
// Port-level checks for the offset to source line table, bound to the top.
module otslt_checker
    import otslt_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    localparam int OFF_LO  = STATUS_W;
    localparam int INFO_LO = STATUS_W + OFFSET_W;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[STATUS_W-1:0] == ST_OK)
                      || (m_tdata[STATUS_W-1:0] == ST_NOT_FOUND)
                      || (m_tdata[STATUS_W-1:0] == ST_FULL))
                     && (m_tdata[TDATA_W-1:ITEM_BITS] == '0))
        else $error("bad status code or nonzero pad");

    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] == ST_FULL)
        |-> (m_tdata[TDATA_W-1:STATUS_W] == '0))
        else $error("full result carries data");

    a_offset_xor_info: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OFF_LO +: OFFSET_W] != '0)
        |-> (m_tdata[INFO_LO +: LINE_W + COLUMN_W] == '0))
        else $error("offset and line info in one result");

endmodule

bind offset_to_source_line_table otslt_checker u_otslt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
